// ===== sv/layer_boundary_generator_top_defines.svh =====
// Assertion macros for the layer boundary generator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef LAYER_BOUNDARY_GENERATOR_TOP_DEFINES_SVH
`define LAYER_BOUNDARY_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTH

// A condition that must hold at every clock edge.
`define LBG_ASSERT(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("lbg assertion failed");

// An antecedent that implies a consequent in the same cycle.
`define LBG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbg assertion failed");

// An antecedent that implies a consequent in the next cycle.
`define LBG_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbg assertion failed");

`else

`define LBG_ASSERT(name, cond)
`define LBG_ASSERT_IMP(name, ante, cons)
`define LBG_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== sv/lbg_pkg.sv =====
package lbg_pkg;

  // Width of every length, Q8.16 millimetres.
  localparam int LEN_W = 24;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Default profile depth.
  localparam int DEFAULT_PROFILE_DEPTH = 256;

  // Restoring division of a 2*LEN_W bit product, one quotient bit per step.
  localparam int DIV_STEPS = 2 * LEN_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Opcodes of an input beat.
  localparam int OPC_W = 2;
  localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPC_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OPC_W-1:0] OP_NEXT   = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_HEIGHT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LAYER_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LAYER_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LAYER_FIXED  = 2'd3;

  // Register reset values.
  localparam logic [LEN_W-1:0] MIN_LAYER_HEIGHT_RST = 24'd4588;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [LEN_W-1:0] point_z;
    logic [LEN_W-1:0] point_height;
  } in_beat_t;

  typedef struct packed {
    logic [LEN_W-1:0] layer_bottom;
    logic [LEN_W-1:0] layer_top;
    logic             done_res;
  } out_beat_t;

endpackage

// ===== sv/layer_boundary_generator_top.sv =====
// Clear, append and unused-opcode beats are handled in S_IDLE, as are requests that are
// already finished, stop at the probe test or emit the fixed first layer; an empty profile
// goes to S_DONE. Otherwise a request walks the cursor through S_NEXT and S_CHECK to S_SEG;
// the last point or a zero-length segment goes to S_DONE, an interpolation through S_MUL,
// S_DIV and S_QUOT first. The result is registered; the next beat waits until it is taken.
// Synchronous reset empties the profile and loads register defaults; memory is kept.
`include "layer_boundary_generator_top_defines.svh"

module layer_boundary_generator_top #(
  parameter int PROFILE_DEPTH = lbg_pkg::DEFAULT_PROFILE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lbg_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lbg_pkg::out_beat_t            out_data,
  input  logic                          cfg_we,
  input  logic [lbg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbg_pkg::LEN_W-1:0]     cfg_wdata
);
  import lbg_pkg::*;

  localparam int AW = $clog2(PROFILE_DEPTH);
  localparam int CW = $clog2(PROFILE_DEPTH + 1);
  localparam int MW = 2 * LEN_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_NEXT  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_SEG   = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_QUOT  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // Configuration registers.
  logic [LEN_W-1:0] obj_height_r;
  logic [LEN_W-1:0] min_lh_r;
  logic [LEN_W-1:0] first_height_r;
  logic             first_fixed_r;

  // Sequencer and generation state.
  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    cursor_r, cursor_nxt;
  logic [LEN_W-1:0] pz_r, pz_nxt;
  logic             first_emit_r, first_emit_nxt;
  logic             finished_r, finished_nxt;
  logic             last_r, last_nxt;

  // Working registers of one request.
  logic [LEN_W:0]   probe_r, probe_nxt;
  logic [LEN_W-1:0] z2_r, z2_nxt;
  logic [LEN_W-1:0] h2_r, h2_nxt;
  logic [LEN_W-1:0] h1_r, h1_nxt;
  logic [LEN_W-1:0] den_r, den_nxt;
  logic [LEN_W-1:0] num_r, num_nxt;
  logic [LEN_W-1:0] diff_r, diff_nxt;
  logic             neg_r, neg_nxt;
  logic [MW-1:0]    prod_r, prod_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [LEN_W-1:0] height_r, height_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r, out_data_nxt;

  // Profile memory: each entry holds {z, height}.
  logic [MW-1:0]    prof_mem [PROFILE_DEPTH];
  logic [MW-1:0]    rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;

  // Combinational helpers.
  logic             in_acc;
  logic [LEN_W:0]   probe_calc;
  logic [CW-1:0]    nxt_idx;
  logic [LEN_W-1:0] rd_z;
  logic [LEN_W-1:0] rd_h;
  logic [LEN_W:0]   probe_off;
  logic [LEN_W:0]   rem_sh;
  logic [LEN_W:0]   rem_sub;
  logic [LEN_W:0]   half_sum;
  logic [LEN_W:0]   top_sum;
  logic [LEN_W-1:0] top_sat;
  logic [LEN_W-1:0] quot;
  out_beat_t        done_beat;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign probe_calc = {1'b0, pz_r} + {2'b00, min_lh_r[LEN_W-1:1]};
  assign nxt_idx    = CW'(cursor_r) + CW'(1);
  assign rd_z       = rd_data_r[MW-1:LEN_W];
  assign rd_h       = rd_data_r[LEN_W-1:0];
  assign probe_off  = probe_r - {1'b0, rd_z};
  assign rem_sh     = {rem_r, prod_r[MW-1]};
  assign rem_sub    = rem_sh - {1'b0, den_r};
  assign half_sum   = {1'b0, pz_r} + {2'b00, height_r[LEN_W-1:1]};
  assign top_sum    = {1'b0, pz_r} + {1'b0, height_r};
  assign top_sat    = top_sum[LEN_W] ? LEN_MAX : top_sum[LEN_W-1:0];
  assign quot       = prod_r[LEN_W-1:0];

  always_comb begin
    done_beat              = '0;
    done_beat.done_res     = 1'b1;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_height_r   <= '0;
      min_lh_r       <= MIN_LAYER_HEIGHT_RST;
      first_height_r <= '0;
      first_fixed_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OBJECT_HEIGHT:      obj_height_r   <= cfg_wdata;
        REG_MIN_LAYER_HEIGHT:   min_lh_r       <= cfg_wdata;
        REG_FIRST_LAYER_HEIGHT: first_height_r <= cfg_wdata;
        REG_FIRST_LAYER_FIXED:  first_fixed_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Profile memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      prof_mem[cnt_r[AW-1:0]] <= {in_data.point_z, in_data.point_height};
    end
    rd_data_r <= prof_mem[rd_addr];
  end

  // Sequencer: cursor walk, segment setup, multiply and bit-serial divide.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cursor_nxt     = cursor_r;
    pz_nxt         = pz_r;
    first_emit_nxt = first_emit_r;
    finished_nxt   = finished_r;
    last_nxt       = last_r;
    probe_nxt      = probe_r;
    z2_nxt         = z2_r;
    h2_nxt         = h2_r;
    h1_nxt         = h1_r;
    den_nxt        = den_r;
    num_nxt        = num_r;
    diff_nxt       = diff_r;
    neg_nxt        = neg_r;
    prod_nxt       = prod_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    height_nxt     = height_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    mem_we         = 1'b0;
    rd_addr        = cursor_r;

    // The waiting result leaves when the far side takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.opcode)
            OP_CLEAR: begin
              cnt_nxt        = '0;
              cursor_nxt     = '0;
              pz_nxt         = '0;
              first_emit_nxt = 1'b0;
              finished_nxt   = 1'b0;
            end
            OP_APPEND: begin
              if (cnt_r < CW'(PROFILE_DEPTH)) begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            OP_NEXT: begin
              if (finished_r) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = done_beat;
              end else if (first_fixed_r && !first_emit_r) begin
                first_emit_nxt            = 1'b1;
                pz_nxt                    = first_height_r;
                out_valid_nxt             = 1'b1;
                out_data_nxt.layer_bottom = '0;
                out_data_nxt.layer_top    = first_height_r;
                out_data_nxt.done_res     = 1'b0;
              end else if (probe_calc >= {1'b0, obj_height_r}) begin
                finished_nxt  = 1'b1;
                out_valid_nxt = 1'b1;
                out_data_nxt  = done_beat;
              end else if (cnt_r == '0) begin
                height_nxt = min_lh_r;
                state_nxt  = S_DONE;
              end else begin
                probe_nxt = probe_calc;
                state_nxt = S_NEXT;
              end
            end
            default: ;
          endcase
        end
      end

      // Read the point after the cursor, or the cursor point if it is the last.
      S_NEXT: begin
        if (nxt_idx < cnt_r) begin
          rd_addr   = nxt_idx[AW-1:0];
          state_nxt = S_CHECK;
        end else begin
          rd_addr   = cursor_r;
          last_nxt  = 1'b1;
          state_nxt = S_SEG;
        end
      end

      // Advance while the probe has reached the next point.
      S_CHECK: begin
        if (probe_r >= {1'b0, rd_z}) begin
          cursor_nxt = cursor_r + AW'(1);
          state_nxt  = S_NEXT;
        end else begin
          z2_nxt    = rd_z;
          h2_nxt    = rd_h;
          rd_addr   = cursor_r;
          last_nxt  = 1'b0;
          state_nxt = S_SEG;
        end
      end

      // Segment start is in the read register: set up the interpolation.
      S_SEG: begin
        h1_nxt = rd_h;
        if (last_r || (z2_r <= rd_z)) begin
          height_nxt = rd_h;
          state_nxt  = S_DONE;
        end else begin
          den_nxt = z2_r - rd_z;
          if (probe_r <= {1'b0, rd_z}) begin
            num_nxt = '0;
          end else if (probe_off >= {1'b0, z2_r - rd_z}) begin
            num_nxt = z2_r - rd_z;
          end else begin
            num_nxt = probe_off[LEN_W-1:0];
          end
          neg_nxt   = (h2_r < rd_h);
          diff_nxt  = (h2_r < rd_h) ? (rd_h - h2_r) : (h2_r - rd_h);
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        prod_nxt  = MW'(diff_r) * MW'(num_r);
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end

      // Restoring division, one quotient bit per cycle shifted into the product.
      S_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt  = rem_sub[LEN_W-1:0];
          prod_nxt = {prod_r[MW-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh[LEN_W-1:0];
          prod_nxt = {prod_r[MW-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_QUOT;
        end
      end

      // The quotient never exceeds the height step, so no wrap.
      S_QUOT: begin
        height_nxt = neg_r ? (h1_r - quot) : (h1_r + quot);
        state_nxt  = S_DONE;
      end

      // Stop test on the half-height midpoint, else emit the layer.
      S_DONE: begin
        out_valid_nxt = 1'b1;
        if (half_sum >= {1'b0, obj_height_r}) begin
          finished_nxt = 1'b1;
          out_data_nxt = done_beat;
        end else begin
          out_data_nxt.layer_bottom = pz_r;
          out_data_nxt.layer_top    = top_sat;
          out_data_nxt.done_res     = 1'b0;
          pz_nxt                    = top_sat;
          first_emit_nxt            = 1'b1;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      cursor_r     <= '0;
      pz_r         <= '0;
      first_emit_r <= 1'b0;
      finished_r   <= 1'b0;
      last_r       <= 1'b0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      cursor_r     <= cursor_nxt;
      pz_r         <= pz_nxt;
      first_emit_r <= first_emit_nxt;
      finished_r   <= finished_nxt;
      last_r       <= last_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    probe_r    <= probe_nxt;
    z2_r       <= z2_nxt;
    h2_r       <= h2_nxt;
    h1_r       <= h1_nxt;
    den_r      <= den_nxt;
    num_r      <= num_nxt;
    diff_r     <= diff_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    height_r   <= height_nxt;
    out_data_r <= out_data_nxt;
  end

  // The profile never holds more points than the memory has entries.
  `LBG_ASSERT(a_cnt_bound, cnt_r <= CW'(PROFILE_DEPTH))
  // The cursor always points at a stored point of a non-empty profile.
  `LBG_ASSERT_IMP(a_cursor_bound, cnt_r != '0, CW'(cursor_r) < cnt_r)
  // The divider remainder stays below the segment length.
  `LBG_ASSERT_IMP(a_rem_bound, state_r == S_DIV, rem_r < den_r)
  // A waiting result means the sequencer is idle.
  `LBG_ASSERT_IMP(a_out_idle, out_valid_r, state_r == S_IDLE)
  // A done beat carries zero lengths; a layer never ends below its bottom.
  `LBG_ASSERT_IMP(a_done_zero, out_valid_r && out_data_r.done_res,
                  out_data_r.layer_bottom == '0 && out_data_r.layer_top == '0)
  `LBG_ASSERT_IMP(a_layer_order, out_valid_r && !out_data_r.done_res,
                  out_data_r.layer_top >= out_data_r.layer_bottom)

endmodule

// ===== sim/tb_layer_boundary_generator_top.sv =====
`timescale 1ns / 1ps

module tb_layer_boundary_generator_top;
  import lbg_pkg::*;

  localparam int PROFILE_DEPTH = DEFAULT_PROFILE_DEPTH;
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [LEN_W-1:0] MM3 = 24'h030000;
  localparam int TARGET_BEATS = 1950;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 600;
  localparam int N_ROWS = 31;

  typedef enum logic [1:0] {ROW_BEAT, ROW_TYPED, ROW_CFG} row_kind_t;

  // One directed step: a register write, or an input beat with an optional fixed answer.
  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    reg_sel;
    logic [LEN_W-1:0]        reg_val;
    in_beat_t                beat;
    out_beat_t               want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  // Shadow registers and generator state of the layer predictor.
  logic [LEN_W-1:0] obj_height;
  logic [LEN_W-1:0] min_lh;
  logic [LEN_W-1:0] first_height;
  logic             first_fixed;
  logic [LEN_W-1:0] prof_z [PROFILE_DEPTH];
  logic [LEN_W-1:0] prof_h [PROFILE_DEPTH];
  int               n_points;
  int               cursor;
  logic [LEN_W-1:0] print_z;
  bit               first_done;
  bit               gen_done;

  out_beat_t expected_layers[$];
  out_beat_t oldest_layer;
  int fail_count = 0;
  int accepted_beats = 0;
  bit quiet_stretch = 1'b0;
  bit hold_request = 1'b0;

  // Directed steps: reset state, fixed first layer, interpolation, zero-length and
  // unsorted segments, zero height, top saturation and the register extremes.
  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_TYPED, REG_OBJECT_HEIGHT, 24'd0, '{OP_NEXT, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b1}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_UNUSED, LEN_MAX, LEN_MAX}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_CFG, REG_OBJECT_HEIGHT, LEN_MAX, '{OP_CLEAR, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_CFG, REG_FIRST_LAYER_HEIGHT, MM3, '{OP_CLEAR, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_CFG, REG_FIRST_LAYER_FIXED, 24'd1, '{OP_CLEAR, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_CLEAR, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_TYPED, REG_OBJECT_HEIGHT, 24'd0, '{OP_NEXT, 24'd0, 24'd0}, '{24'd0, MM3, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_NEXT, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_APPEND, 24'h000000, 24'h003333},
      '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_APPEND, 24'h0A0000, 24'h00CCCC},
      '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_APPEND, 24'h0A0000, 24'h000000},
      '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_APPEND, 24'h140000, 24'h001000},
      '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_NEXT, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_NEXT, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_APPEND, 24'h050000, 24'h008000},
      '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_NEXT, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_CLEAR, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_APPEND, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_TYPED, REG_OBJECT_HEIGHT, 24'd0, '{OP_NEXT, 24'd0, 24'd0}, '{24'd0, MM3, 1'b0}},
    '{ROW_TYPED, REG_OBJECT_HEIGHT, 24'd0, '{OP_NEXT, 24'd0, 24'd0}, '{MM3, MM3, 1'b0}},
    '{ROW_TYPED, REG_OBJECT_HEIGHT, 24'd0, '{OP_NEXT, 24'd0, 24'd0}, '{MM3, MM3, 1'b0}},
    '{ROW_CFG, REG_MIN_LAYER_HEIGHT, LEN_MAX, '{OP_CLEAR, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_CFG, REG_FIRST_LAYER_FIXED, 24'd0, '{OP_CLEAR, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_CLEAR, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_APPEND, 24'd0, LEN_MAX}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_TYPED, REG_OBJECT_HEIGHT, 24'd0, '{OP_NEXT, 24'd0, 24'd0}, '{24'd0, LEN_MAX, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_CLEAR, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_APPEND, 24'd0, LEN_MAX}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_APPEND, LEN_MAX, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_NEXT, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}},
    '{ROW_BEAT, REG_OBJECT_HEIGHT, 24'd0, '{OP_NEXT, 24'd0, 24'd0}, '{24'd0, 24'd0, 1'b0}}
  };

  layer_boundary_generator_top #(
    .PROFILE_DEPTH(PROFILE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Empty the profile and start generation again from z = 0.
  function automatic void restart_layers();
    n_points = 0;
    cursor = 0;
    print_z = '0;
    first_done = 1'b0;
    gen_done = 1'b0;
  endfunction

  // Height at the probe point: walk the cursor forward, then interpolate toward the
  // next point with the fraction clamped to 0..1 and the step truncated toward h1.
  function automatic logic [LEN_W-1:0] profile_height(input logic [LEN_W:0] probe);
    logic [LEN_W-1:0] z1;
    logic [LEN_W-1:0] h1;
    logic [LEN_W-1:0] z2;
    logic [LEN_W-1:0] h2;
    logic [LEN_W-1:0] den;
    logic [LEN_W:0]   num;
    logic [2*LEN_W-1:0] span;
    if (n_points == 0) return min_lh;
    while (cursor + 1 < n_points && probe >= prof_z[cursor + 1]) cursor++;
    z1 = prof_z[cursor];
    h1 = prof_h[cursor];
    if (cursor + 1 >= n_points) return h1;
    z2 = prof_z[cursor + 1];
    h2 = prof_h[cursor + 1];
    // A segment of zero or negative length keeps its start height.
    if (z2 <= z1) return h1;
    den = z2 - z1;
    num = (probe > z1) ? probe - z1 : '0;
    if (num > den) num = den;
    if (h2 >= h1) begin
      span = (48'(h2 - h1) * 48'(num)) / 48'(den);
      return h1 + span[LEN_W-1:0];
    end
    span = (48'(h1 - h2) * 48'(num)) / 48'(den);
    return h1 - span[LEN_W-1:0];
  endfunction

  // Apply one input beat to the predictor. Returns 1 when the beat has an effect;
  // has_layer tells whether a result beat follows.
  function automatic bit predict_layer(input in_beat_t beat, output bit has_layer,
                                       output out_beat_t layer);
    logic [LEN_W:0]   probe;
    logic [LEN_W:0]   top;
    logic [LEN_W-1:0] h;
    has_layer = 1'b0;
    layer = '0;
    layer.done_res = 1'b1;
    case (beat.opcode)
      OP_CLEAR: begin
        restart_layers();
        return 1'b1;
      end
      OP_APPEND: begin
        // A full profile drops further points.
        if (n_points >= PROFILE_DEPTH) return 1'b0;
        prof_z[n_points] = beat.point_z;
        prof_h[n_points] = beat.point_height;
        n_points++;
        return 1'b1;
      end
      OP_NEXT: ;
      default: return 1'b0;
    endcase
    has_layer = 1'b1;
    if (gen_done) return 1'b1;
    // The fixed first layer comes first and ignores the object height.
    if (first_fixed && !first_done) begin
      first_done = 1'b1;
      print_z = first_height;
      layer.layer_top = first_height;
      layer.done_res = 1'b0;
      return 1'b1;
    end
    probe = {1'b0, print_z} + (min_lh >> 1);
    if (probe >= obj_height) begin
      gen_done = 1'b1;
      return 1'b1;
    end
    h = profile_height(probe);
    if ({1'b0, print_z} + (h >> 1) >= obj_height) begin
      gen_done = 1'b1;
      return 1'b1;
    end
    top = {1'b0, print_z} + h;
    if (top > LEN_MAX) top = LEN_MAX;
    layer.layer_bottom = print_z;
    layer.layer_top = top[LEN_W-1:0];
    layer.done_res = 1'b0;
    print_z = top[LEN_W-1:0];
    first_done = 1'b1;
    return 1'b1;
  endfunction

  function automatic in_beat_t make_beat(input logic [OPC_W-1:0] op,
                                         input logic [LEN_W-1:0] z,
                                         input logic [LEN_W-1:0] h);
    in_beat_t beat;
    beat.opcode = op;
    beat.point_z = z;
    beat.point_height = h;
    return beat;
  endfunction

  // Layer heights scaled to the object, with rare zero and full-scale values.
  function automatic logic [LEN_W-1:0] rand_height();
    int unsigned pick;
    pick = $urandom_range(0, 49);
    if (pick == 0) return '0;
    if (pick == 1) return LEN_MAX;
    return 24'($urandom_range(obj_height / 64 + 1, obj_height / 6 + 1));
  endfunction

  // Offer one beat after a random gap and hold it until accepted.
  task automatic send_beat(input in_beat_t beat, input bit typed, input out_beat_t typed_layer);
    int unsigned pick;
    int gap;
    bit has_layer;
    out_beat_t layer;
    gap = 0;
    if (!quiet_stretch) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90) gap = $urandom_range(8, 40);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_layer(beat, has_layer, layer)) accepted_beats++;
    if (has_layer) expected_layers = {expected_layers, (typed ? typed_layer : layer)};
  endtask

  // Stop offering and wait until every expected layer has come out.
  task automatic drain_layers();
    in_valid <= 1'b0;
    while (expected_layers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] sel, input logic [LEN_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    case (sel)
      REG_OBJECT_HEIGHT:      obj_height = value;
      REG_MIN_LAYER_HEIGHT:   min_lh = value;
      REG_FIRST_LAYER_HEIGHT: first_height = value;
      REG_FIRST_LAYER_FIXED:  first_fixed = value[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Compare each accepted result beat with the oldest expected layer.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_layers.size() == 0) begin
        $error("result beat with no layer expected: %h", out_data);
        fail_count++;
      end else begin
        oldest_layer = expected_layers.pop_front();
        if (out_data.layer_bottom !== oldest_layer.layer_bottom) begin
          $error("layer_bottom mismatch: expected %h, got %h",
                 oldest_layer.layer_bottom, out_data.layer_bottom);
          fail_count++;
        end
        if (out_data.layer_top !== oldest_layer.layer_top) begin
          $error("layer_top mismatch: expected %h, got %h",
                 oldest_layer.layer_top, out_data.layer_top);
          fail_count++;
        end
        if (out_data.done_res !== oldest_layer.done_res) begin
          $error("done_res mismatch: expected %b, got %b",
                 oldest_layer.done_res, out_data.done_res);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stall runs, one long hold-off on request, none in quiet stretches.
  initial begin
    int unsigned pick;
    int run;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet_stretch) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_stall <= 1'b0;
          run = $urandom_range(1, 6);
        end else if (pick < 95) begin
          out_stall <= 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(15, 60);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin
    #(60_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int row;
    int seq;
    int i;
    int npts;
    int nreq;
    int unsigned z_step;
    int unsigned pz;
    logic [LEN_W-1:0] z_beat;
    logic [LEN_W-1:0] new_obj;
    logic [LEN_W-1:0] new_min;
    logic [LEN_W-1:0] new_first;
    logic new_fixed;

    obj_height = '0;
    min_lh = MIN_LAYER_HEIGHT_RST;
    first_height = '0;
    first_fixed = 1'b0;
    restart_layers();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (row = 0; row < N_ROWS; row++) begin
      if (directed_rows[row].kind == ROW_CFG) begin
        drain_layers();
        write_register(directed_rows[row].reg_sel, directed_rows[row].reg_val);
      end else begin
        send_beat(directed_rows[row].beat, directed_rows[row].kind == ROW_TYPED,
                  directed_rows[row].want);
      end
    end

    // Random sequences: clear, a mostly sorted profile, then a run of layer requests.
    seq = 0;
    while (accepted_beats < TARGET_BEATS) begin
      // New register settings every dozen sequences, extremes first.
      if (seq % 12 == 0) begin
        drain_layers();
        case (seq / 12)
          0: begin
            new_obj = LEN_MAX;
            new_min = 24'd1;
            new_first = '0;
            new_fixed = 1'b1;
          end
          1: begin
            new_obj = '0;
            new_min = LEN_MAX;
            new_first = LEN_MAX;
            new_fixed = 1'b1;
          end
          default: begin
            new_obj = 24'($urandom_range(32'h010000, 32'hFFFFFF));
            new_min = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(1, 32'hFFFFFF))
                                                  : 24'($urandom_range(1, new_obj / 16 + 1));
            new_first = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                    : 24'($urandom_range(0, new_obj / 8));
            new_fixed = 1'($urandom);
          end
        endcase
        write_register(REG_OBJECT_HEIGHT, new_obj);
        write_register(REG_MIN_LAYER_HEIGHT, new_min);
        write_register(REG_FIRST_LAYER_HEIGHT, new_first);
        write_register(REG_FIRST_LAYER_FIXED, {23'($urandom), new_fixed});
        // The first random sequence runs against a long receiver hold-off.
        if (seq == 0) hold_request = 1'b1;
      end
      quiet_stretch = ($urandom_range(0, 5) == 0);

      // Now and then the clear is left out and the old profile carries on.
      if ($urandom_range(0, 9) != 0)
        send_beat(make_beat(OP_CLEAR, 24'($urandom), 24'($urandom)), 1'b0, '0);

      // Two sequences overfill the profile; the rest keep it short.
      npts = (seq == 4 || seq == 70) ? PROFILE_DEPTH + 2 : $urandom_range(0, 8);
      z_step = obj_height / (npts + 1) + 1;
      pz = $urandom_range(0, obj_height / 8);
      for (i = 0; i < npts; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          z_beat = 24'($urandom);
        end else begin
          z_beat = 24'(pz);
          pz += $urandom_range(0, 2 * z_step);
          if (pz > LEN_MAX) pz = LEN_MAX;
        end
        send_beat(make_beat(OP_APPEND, z_beat, rand_height()), 1'b0, '0);
      end

      // Layer requests, with stray appends and unused opcodes mixed in.
      nreq = $urandom_range(3, 40);
      for (i = 0; i < nreq; i++) begin
        if ($urandom_range(0, 11) == 0)
          send_beat(make_beat($urandom_range(0, 1) ? OP_UNUSED : OP_APPEND,
                              24'($urandom), rand_height()), 1'b0, '0);
        send_beat(make_beat(OP_NEXT, 24'($urandom), 24'($urandom)), 1'b0, '0);
        if (gen_done && $urandom_range(0, 2) == 0) break;
      end
      seq++;
    end

    quiet_stretch = 1'b0;
    drain_layers();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
